[rtl/core/rwa_pkg.sv]
// Shared widths, codes, item types and helper functions of the rain window accumulator.
package rwa_pkg;

  localparam int unsigned HISTORY_DEPTH = 64;

  localparam int unsigned IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned TIME_W = 32;
  localparam int unsigned READ_W = 24;
  localparam int unsigned RET_W  = 24;
  localparam int unsigned WIN_W  = 16;
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned REC_W  = TIME_W + READ_W;

  // Accumulators hold the full sum of all records and at least one bit above the result width.
  localparam int unsigned SUM_RAW_W = READ_W + $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W     = (SUM_RAW_W > OUT_W + 1) ? SUM_RAW_W : OUT_W + 1;

  // The rate scale of 3600 is applied as 4096 - 512 + 16.
  localparam int unsigned RATE_SH_A = 12;
  localparam int unsigned RATE_SH_B = 9;
  localparam int unsigned RATE_SH_C = 4;
  localparam int unsigned NUM_W     = SUM_W + RATE_SH_A;
  localparam int unsigned MIN_SPAN  = 60;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETENTION      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_WINDOW    = 2'd2;

  localparam logic [RET_W-1:0] RETENTION_RESET   = RET_W'(172800);
  localparam logic [WIN_W-1:0] RATE_WINDOW_RESET = WIN_W'(3600);

  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] now_time;
    logic [TIME_W-1:0] sample_time;
    logic [READ_W-1:0] rain_counter;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] window_total;
    logic [OUT_W-1:0] rate_per_hour;
  } out_item_t;

  // Ring slot of the record k places after the head.
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] k);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(k);
    if (s >= (CNT_W+1)'(HISTORY_DEPTH)) begin
      s = s - (CNT_W+1)'(HISTORY_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] sat_sum(input logic [SUM_W-1:0] v);
    return (|v[SUM_W-1:OUT_W]) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] sat_num(input logic [NUM_W-1:0] v);
    return (|v[NUM_W-1:OUT_W]) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
  endfunction

endpackage

[rtl/core/rwa_if.sv]
// Valid/ready channel interfaces for the request and result items.
interface rwa_in_if;
  import rwa_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rwa_out_if;
  import rwa_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/rwa_ram.sv]
// Generic single write port, single read port memory with a registered read.
module rwa_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 56,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/rwa_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module rwa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rwa_pkg::NUM_W-1:0] num_i,
  input  logic [rwa_pkg::TIME_W-1:0] den_i,
  output logic                      done_o,
  output logic [rwa_pkg::NUM_W-1:0] quot_o
);
  import rwa_pkg::*;

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [TIME_W-1:0] den_q, den_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic [TIME_W:0]   trial;
  logic              qbit;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    trial  = {rem_q, num_q[NUM_W-1]};
    qbit   = (trial >= {1'b0, den_q});
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(NUM_W);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so the trial difference fits.
      rem_d  = qbit ? TIME_W'(trial - {1'b0, den_q}) : trial[TIME_W-1:0];
      num_d  = {num_q[NUM_W-2:0], qbit};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

[rtl/core/rain_window_accumulator_unit.sv]
// Top level of the rain window accumulator: record ring, walk sequencer and result register.
//
// The unit follows the cumulative counter of a rain gauge and keeps a ring of up to
// HISTORY_DEPTH timestamped increments in a single-port-read memory. It handles one item
// at a time: input ready is high only while the sequencer is idle, and a finished result
// waits in its own output register so the next item can be taken before it is consumed.
// A tick item reads the head record while idle and compares it in the check state. A
// report with history disabled goes straight to the result state. A report with
// history enabled walks every stored record through the one memory read port, one per
// cycle, then forms the scaled window sum and runs the bit-serial divider, which yields
// one quotient bit per cycle over NUM_W bits (45 at the default depth). When the rate is
// zero (no record in the window, or a span of 60 seconds or less) the divider is skipped.
// Results are produced only for reports; the sum and rate are computed before the new
// reading is stored. Configuration writes are to be made only while no item is in flight;
// the record memory needs no clearing after reset because only live entries are read.
module rain_window_accumulator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rwa_in_if.sink                         in_ch,
  rwa_out_if.source                      out_ch,
  input  logic                           cfg_we_i,
  input  logic [rwa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rwa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rwa_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TCHK   = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_RESULT = 3'd5;
  localparam logic [2:0] ST_PUSH   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [READ_W-1:0] prev_q, prev_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic              pend_q, pend_d;
  logic [SUM_W-1:0]  total_q, total_d;
  logic [SUM_W-1:0]  wsum_q, wsum_d;
  logic [TIME_W-1:0] beg_q, beg_d;
  logic              have_beg_q, have_beg_d;
  logic [OUT_W-1:0]  rate_q, rate_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  logic              hist_en_q;
  logic [RET_W-1:0]  ret_q;
  logic [WIN_W-1:0]  win_q;

  // Item payload, held for the whole time the item is worked on.
  logic              req_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] stime_q;
  logic [READ_W-1:0] value_q;

  logic              in_fire;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [REC_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [REC_W-1:0]  mem_rdata;
  logic [TIME_W-1:0] rec_time;
  logic [READ_W-1:0] rec_delta;
  logic              in_window;
  logic              expired;
  logic              span_ok;
  logic [READ_W-1:0] eff_prev;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_num;
  logic [NUM_W-1:0]  div_quot;

  assign in_fire   = in_ch.valid && (state_q == ST_IDLE);
  assign rec_time  = mem_rdata[REC_W-1:READ_W];
  assign rec_delta = mem_rdata[READ_W-1:0];

  // Window and expiry tests are done one bit wider so that time plus offset never wraps.
  assign in_window = ({1'b0, rec_time} + (TIME_W+1)'(win_q)) > {1'b0, now_q};
  assign expired   = ({1'b0, rec_time} + (TIME_W+1)'(ret_q)) < {1'b0, now_q};
  assign span_ok   = {1'b0, now_q} > ({1'b0, beg_q} + (TIME_W+1)'(MIN_SPAN));

  // A zero previous reading is first replaced by the new one.
  assign eff_prev = (prev_q == '0) ? value_q : prev_q;

  assign div_num = (NUM_W'(wsum_q) << RATE_SH_A) - (NUM_W'(wsum_q) << RATE_SH_B)
                 + (NUM_W'(wsum_q) << RATE_SH_C);
  assign div_start = (state_q == ST_MUL) && have_beg_q && span_ok;

  // The head is read while idle so a tick finds its record in the check state that follows.
  assign mem_raddr = (state_q == ST_WALK) ? slot_add(head_q, k_q) : head_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    prev_d      = prev_q;
    k_d         = k_q;
    pend_d      = 1'b0;
    total_d     = total_q;
    wsum_d      = wsum_q;
    beg_d       = beg_q;
    have_beg_d  = have_beg_q;
    rate_d      = rate_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = head_q;
    mem_wdata   = {stime_q, READ_W'(value_q - eff_prev)};

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          k_d        = '0;
          total_d    = '0;
          wsum_d     = '0;
          have_beg_d = 1'b0;
          rate_d     = '0;
          if (in_ch.data.req_type == REQ_TICK) begin
            if (hist_en_q && (count_q != '0)) begin
              state_d = ST_TCHK;
            end
          end else begin
            state_d = hist_en_q ? ST_WALK : ST_RESULT;
          end
        end
      end
      ST_TCHK: begin
        if (expired) begin
          head_d  = slot_add(head_q, CNT_W'(1));
          count_d = count_q - CNT_W'(1);
        end
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        // One read is issued per cycle; its data is added in the next cycle.
        if (k_q < count_q) begin
          k_d    = k_q + CNT_W'(1);
          pend_d = 1'b1;
        end else if (!pend_q) begin
          state_d = ST_MUL;
        end
        if (pend_q) begin
          total_d = total_q + SUM_W'(rec_delta);
          if (in_window) begin
            wsum_d = wsum_q + SUM_W'(rec_delta);
            if (!have_beg_q) begin
              beg_d      = rec_time;
              have_beg_d = 1'b1;
            end
          end
        end
      end
      ST_MUL: begin
        state_d = div_start ? ST_DIV : ST_RESULT;
      end
      ST_DIV: begin
        if (div_done) begin
          rate_d  = sat_num(div_quot);
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d              = 1'b1;
          out_data_d.window_total  = sat_sum(total_q);
          out_data_d.rate_per_hour = rate_q;
          state_d                  = hist_en_q ? ST_PUSH : ST_IDLE;
        end
      end
      ST_PUSH: begin
        if (value_q > eff_prev) begin
          mem_we = 1'b1;
          prev_d = value_q;
          if (count_q == CNT_W'(HISTORY_DEPTH)) begin
            // A full ring overwrites its oldest record and moves the head on.
            mem_waddr = head_q;
            head_d    = slot_add(head_q, CNT_W'(1));
          end else begin
            mem_waddr = slot_add(head_q, count_q);
            count_d   = count_q + CNT_W'(1);
          end
        end else begin
          prev_d = eff_prev;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      prev_q      <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      have_beg_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_en_q   <= 1'b0;
      ret_q       <= RETENTION_RESET;
      win_q       <= RATE_WINDOW_RESET;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      prev_q      <= prev_d;
      k_q         <= k_d;
      pend_q      <= pend_d;
      have_beg_q  <= have_beg_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_HISTORY_ENABLE: hist_en_q <= cfg_data_i[0];
          REG_RETENTION:      ret_q     <= cfg_data_i[RET_W-1:0];
          REG_RATE_WINDOW:    win_q     <= cfg_data_i[WIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    total_q    <= total_d;
    wsum_q     <= wsum_d;
    beg_q      <= beg_d;
    rate_q     <= rate_d;
    out_data_q <= out_data_d;
    if (in_fire) begin
      req_q   <= in_ch.data.req_type;
      now_q   <= in_ch.data.now_time;
      stime_q <= in_ch.data.sample_time;
      value_q <= in_ch.data.rain_counter;
    end
  end

  rwa_ram #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (REC_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rwa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (TIME_W'(now_q - beg_q)),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign in_ch.ready  = (state_q == ST_IDLE);
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_data_q;

  // The ring never holds more records than it has slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(HISTORY_DEPTH))
    else $error("record count above ring depth");

  // A new result appears only out of the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_RESULT)
    else $error("result valid raised outside the result state");

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  // Ticks never enter the record walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (req_q == REQ_REPORT))
    else $error("tick item entered the record walk");

endmodule

[tb/testbench.sv]
// Self-checking testbench of the rain window accumulator with a built-in prediction of its sums.
module testbench;
  import rwa_pkg::*;

  // Clock period is 8 units; reset is held low at the start of the run.
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 7;
  // A quiet stretch after the last result is enough for any tick that is still in
  // flight to finish.
  localparam int SETTLE_CYCLES = 200;
  // Length of the receiver's hold-off, during which it takes no results so that the unit backs up.
  localparam int HOLD_OFF_CYCLES = 400;
  // This limit leaves a margin over the slowest correct run of roughly 1500 items.
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_SHOWN = 40;
  // The gauge level never climbs past this value before the final items, because the
  // stored reading can only grow and a saturated counter would stop all recording.
  localparam int unsigned LEVEL_CAP = 16_000_000;
  localparam longint unsigned RATE_SCALE = 3600;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Predicts the answer of every report from its own copy of the record ring, the stored
  // reading and the register settings, and compares the results as they come out.
  class rain_sum_checker;
    logic [TIME_W-1:0] rec_time[HISTORY_DEPTH];
    logic [READ_W-1:0] rec_rise[HISTORY_DEPTH];
    int unsigned head_slot;
    int unsigned live_count;
    logic [READ_W-1:0] last_reading;
    logic history_on;
    logic [RET_W-1:0] retention;
    logic [WIN_W-1:0] rate_window;
    out_item_t expected_sums[$];
    int mismatch_count;
    int reports_seen;
    int ticks_seen;
    int results_checked;
    int expiries;
    int evictions;
    int nonzero_rates;

    function new();
      head_slot = 0;
      live_count = 0;
      last_reading = '0;
      history_on = 1'b0;
      retention = RETENTION_RESET;
      rate_window = RATE_WINDOW_RESET;
      mismatch_count = 0;
      reports_seen = 0;
      ticks_seen = 0;
      results_checked = 0;
      expiries = 0;
      evictions = 0;
      nonzero_rates = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_HISTORY_ENABLE: history_on = value[0];
        REG_RETENTION: retention = value[RET_W-1:0];
        REG_RATE_WINDOW: rate_window = value[WIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    // Updates the ring for an accepted item and, for a report, queues its expected sums.
    function void note_item(in_item_t req);
      longint unsigned now;
      longint unsigned stamp;
      longint unsigned total;
      longint unsigned in_window;
      longint unsigned first_t;
      longint unsigned rate;
      bit have_first;
      int unsigned slot;
      out_item_t sums;
      now = 64'(req.now_time);
      if (req.req_type == REQ_TICK) begin
        ticks_seen++;
        // Only the head record can expire, and only once it is strictly older than
        // the retention time; the sum is formed at 64 bits so it never wraps.
        if (history_on && live_count > 0) begin
          stamp = 64'(rec_time[head_slot]);
          if (stamp + retention < now) begin
            head_slot = (head_slot + 1) % HISTORY_DEPTH;
            live_count--;
            expiries++;
          end
        end
        return;
      end
      reports_seen++;
      sums = '0;
      if (history_on) begin
        total = 0;
        in_window = 0;
        first_t = 0;
        rate = 0;
        have_first = 1'b0;
        for (int unsigned k = 0; k < live_count; k++) begin
          slot = (head_slot + k) % HISTORY_DEPTH;
          stamp = 64'(rec_time[slot]);
          total += 64'(rec_rise[slot]);
          if (stamp + rate_window > now) begin
            in_window += 64'(rec_rise[slot]);
            if (!have_first) begin
              first_t = stamp;
              have_first = 1'b1;
            end
          end
        end
        if (have_first && now > first_t + MIN_SPAN) begin
          rate = (in_window * RATE_SCALE) / (now - first_t);
        end
        sums.window_total = (total > 64'hFFFF_FFFF) ? '1 : total[OUT_W-1:0];
        sums.rate_per_hour = (rate > 64'hFFFF_FFFF) ? '1 : rate[OUT_W-1:0];
        if (rate != 0) begin
          nonzero_rates++;
        end
        // The sums above are taken before the new reading is stored.
        if (last_reading == 0) begin
          last_reading = req.rain_counter;
        end
        if (req.rain_counter > last_reading) begin
          if (live_count >= HISTORY_DEPTH) begin
            head_slot = (head_slot + 1) % HISTORY_DEPTH;
            live_count = HISTORY_DEPTH - 1;
            evictions++;
          end
          slot = (head_slot + live_count) % HISTORY_DEPTH;
          rec_time[slot] = req.sample_time;
          rec_rise[slot] = req.rain_counter - last_reading;
          live_count++;
          last_reading = req.rain_counter;
        end
      end
      expected_sums.insert(expected_sums.size(), sums);
    endfunction

    task report(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN) begin
        $display("MISMATCH: %s", msg);
      end
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_sums.size() == 0) begin
        report($sformatf("result total=%0d rate=%0d arrived with nothing expected",
                         got.window_total, got.rate_per_hour));
        return;
      end
      want = expected_sums.pop_front();
      results_checked++;
      if (got.window_total !== want.window_total) begin
        report($sformatf("result %0d: window_total %0d, expected %0d",
                         results_checked, got.window_total, want.window_total));
      end
      if (got.rate_per_hour !== want.rate_per_hour) begin
        report($sformatf("result %0d: rate_per_hour %0d, expected %0d",
                         results_checked, got.rate_per_hour, want.rate_per_hour));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rwa_in_if in_ch ();
  rwa_out_if out_ch ();

  rain_window_accumulator_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  rain_sum_checker sb;

  // The stimulus asks for a long hold-off by bumping this count; the receiver counts the
  // held cycles on its own.
  int hold_requests = 0;
  bit gapless = 1'b0;
  int settings_used = 0;

  // The simulated gauge: its clock in seconds and its cumulative level.
  logic [TIME_W-1:0] gauge_time;
  int unsigned gauge_level;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Idle lengths for both sides: mostly none or short, now and then long.
  function automatic int pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(20, 80);
  endfunction

  // Offers one item after an optional gap and waits until the unit takes it. The valid
  // line stays high across back-to-back items, so it is never lowered and raised again
  // within one time step.
  task automatic send_item(input in_item_t req);
    int gap;
    gap = gapless ? 0 : pick_pause();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= req;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_item(req);
  endtask

  task automatic send_report(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] stamp,
                             input logic [READ_W-1:0] level);
    in_item_t req;
    req.req_type = REQ_REPORT;
    req.now_time = now;
    req.sample_time = stamp;
    req.rain_counter = level;
    send_item(req);
  endtask

  // A tick carries random stamp and counter fields; the unit must ignore them.
  task automatic send_tick(input logic [TIME_W-1:0] now);
    in_item_t req;
    req.req_type = REQ_TICK;
    req.now_time = now;
    req.sample_time = $urandom;
    req.rain_counter = READ_W'($urandom);
    send_item(req);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    sb.set_reg(idx, value);
  endtask

  // Writes all three registers. Bits above the width of the enable and rate window registers
  // carry random junk, which the unit has to drop.
  task automatic set_regs(input bit enable, input int unsigned keep_s, input int unsigned win_s);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_HISTORY_ENABLE, {junk[CFG_DATA_W-1:1], enable});
    write_reg(REG_RETENTION, keep_s[RET_W-1:0]);
    write_reg(REG_RATE_WINDOW, {junk[CFG_DATA_W-1:WIN_W], win_s[WIN_W-1:0]});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Stops offering items, waits for every expected result and then for any tick that
  // may still be at work, so that the registers can be written safely.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random traffic shaped like a working gauge: mostly reports with a rising counter and
  // plausible stamps, ticks in between, and a small share of noise with random times.
  task automatic run_gauge_phase(input int n_items, input bit hold_mid);
    int unsigned r;
    int unsigned adv;
    in_item_t req;
    for (int i = 0; i < n_items; i++) begin
      if (i % 32 == 0) begin
        gapless = ($urandom_range(0, 3) == 0);
      end
      if (hold_mid && i == n_items / 3) begin
        hold_requests++;
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        adv = $urandom_range(1, 120);
      end else if (r < 92) begin
        adv = $urandom_range(121, 2000);
      end else if (r < 99) begin
        adv = $urandom_range(2001, 40000);
      end else begin
        adv = $urandom_range(40001, 400000);
      end
      gauge_time += adv;
      req.now_time = gauge_time;
      req.sample_time = $urandom;
      req.rain_counter = READ_W'($urandom_range(0, gauge_level));
      r = $urandom_range(0, 99);
      if (r < 68) begin
        req.req_type = REQ_REPORT;
        r = $urandom_range(0, 99);
        if (r < 80) begin
          req.sample_time = gauge_time - $urandom_range(0, 30);
        end else if (r < 92) begin
          req.sample_time = gauge_time + $urandom_range(0, 30);
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
          adv = $urandom_range(1, 300);
        end else if (r < 65) begin
          adv = $urandom_range(301, 20000);
        end else if (r < 68) begin
          adv = $urandom_range(20001, 400000);
        end else begin
          adv = 0;
        end
        if (adv > 0 && gauge_level + adv <= LEVEL_CAP) begin
          gauge_level += adv;
          req.rain_counter = READ_W'(gauge_level);
        end else if (r < 85) begin
          // The gauge repeats its last reading.
          req.rain_counter = READ_W'(gauge_level);
        end
      end else if (r < 96) begin
        req.req_type = REQ_TICK;
      end else begin
        // Noise: any item type at a random time.
        req.req_type = 1'($urandom_range(0, 1));
        req.now_time = $urandom;
      end
      send_item(req);
    end
  endtask

  // Result receiver: stretches of free flow alternate with stretches of random stalls,
  // and a requested hold-off keeps ready low for a long fixed stretch.
  initial begin
    int seg_left;
    int stall_left;
    int stall_pct;
    int hold_left;
    int holds_done;
    seg_left = 0;
    stall_left = 0;
    stall_pct = 0;
    hold_left = 0;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_requests) begin
        hold_left = HOLD_OFF_CYCLES;
        holds_done++;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 400);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 10;
          2: stall_pct = 30;
          default: stall_pct = 60;
        endcase
      end
      seg_left--;
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(1, 100) <= stall_pct) begin
          stall_left = pick_pause();
        end
      end
    end
  end

  // Results are compared at the edge that accepts them.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.data);
    end
  end

  // Watchdog on the whole run.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sb = new();
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Settings after reset have history disabled: every report answers zero, nothing is
    // stored and the stored reading stays zero even for an all-ones counter.
    send_report('1, '1, '1);
    send_report('0, '0, '0);
    send_tick(32'd5000);
    wait_idle();

    // A write to the index past the last register must change nothing.
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    set_regs(1'b1, 172800, 3600);
    // A zero reading leaves the stored reading at zero; the next reading becomes the
    // first one and stores nothing; falling and equal readings store nothing either.
    send_report(32'd1000, 32'd1000, 24'd0);
    send_report(32'd1010, 32'd1010, 24'd500);
    send_report(32'd1020, 32'd1020, 24'd400);
    send_report(32'd1030, 32'd1030, 24'd500);
    send_report(32'd1040, 32'd1040, 24'd700);
    // Spans of 50 and exactly 60 seconds still give a zero rate.
    send_report(32'd1090, 32'd1090, 24'd1000);
    // This record is stamped at time zero, which is a real record time.
    send_report(32'd1100, 32'd0, 24'd1100);
    send_report(32'd1101, 32'd1101, 24'd1100);
    send_tick(32'd1200);
    // The record at 1040 sits exactly on the window edge and is left out.
    send_report(32'd4640, 32'd4640, 24'd2000000);
    send_report(32'd4701, 32'd4701, 24'd2000000);
    wait_idle();

    // Retention of one second and widest window: expiry needs the head strictly older.
    set_regs(1'b1, 1, 65535);
    send_tick(32'd1041);
    send_tick(32'd4702);
    send_tick(32'd4702);
    send_tick(32'd4702);
    send_tick(32'd4702);
    send_tick(32'd4702);
    send_report(32'd4703, 32'd4703, 24'd2000);
    wait_idle();
    gauge_level = 2000000;

    // Random phases over a spread of settings, the extremes among them.
    set_regs(1'b1, $urandom_range(200, 3000), 3600);
    gauge_time = $urandom_range(0, 32'hEFFF_FFFF);
    run_gauge_phase(180, 1'b1);
    wait_idle();

    set_regs(1'b1, 16777215, 65535);
    run_gauge_phase(180, 1'b0);
    wait_idle();

    set_regs(1'b1, 1, 1);
    run_gauge_phase(170, 1'b0);
    wait_idle();

    set_regs(1'b0, $urandom_range(1, 5000), $urandom_range(1, 65535));
    run_gauge_phase(70, 1'b0);
    wait_idle();

    // The gauge clock runs past the top of the 32-bit range here.
    set_regs(1'b1, $urandom_range(1, 20000), $urandom_range(1, 65535));
    gauge_time = 32'hFFFF_C000;
    run_gauge_phase(180, 1'b0);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      set_regs(1'b1, $urandom_range(1, 50000), $urandom_range(60, 7200));
      gauge_time = $urandom;
      run_gauge_phase(220, p == 1);
      wait_idle();
    end

    // The counter finally jumps to its largest value and is summed once more.
    gauge_time += 100;
    send_report(gauge_time, gauge_time, '1);
    gauge_time += 100;
    send_report(gauge_time, gauge_time, '1);
    wait_idle();

    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    end
    $display("Run covered %0d reports and %0d ticks over %0d register settings;",
             sb.reports_seen, sb.ticks_seen, settings_used);
    $display("%0d results checked, records expired %0d, evicted %0d, nonzero rates %0d.",
             sb.results_checked, sb.expiries, sb.evictions, sb.nonzero_rates);
    if (sb.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
